/* rtl/core/ocps_pkg.sv */
// ----------------------------------------------------------------------------
// ocps_pkg
// Shared types, constants and helpers of the oriented cylinder point sampler.
// ----------------------------------------------------------------------------
package ocps_pkg;

	// one input transaction
	typedef struct packed {
		logic [15:0] slab_start;
		logic [15:0] slab_end;
		logic [14:0] rand_radial;
		logic [15:0] rand_turn;
		logic [14:0] rand_level;
	} in_item_t;

	// one result transaction
	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic               axis_degenerate;
	} out_item_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_RADIUS   = 3'd0,
		REG_HEIGHT   = 3'd1,
		REG_CENTER_X = 3'd2,
		REG_CENTER_Y = 3'd3,
		REG_CENTER_Z = 3'd4,
		REG_AXIS_X   = 3'd5,
		REG_AXIS_Y   = 3'd6,
		REG_AXIS_Z   = 3'd7
	} cfg_reg_t;

	// orthonormal basis, Q2.30 components
	typedef struct packed {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic signed [31:0] ux;
		logic signed [31:0] uy;
		logic signed [31:0] uz;
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic signed [31:0] fz;
		logic               deg;
	} basis_t;

	// front end to iterative stages
	typedef struct packed {
		logic [14:0]        rand_radial;
		logic [15:0]        rand_turn;
		logic signed [31:0] ly;
	} iter_in_t;

	// iterative stages to rotation stages
	typedef struct packed {
		logic [14:0]        sq;
		logic signed [31:0] c;
		logic signed [31:0] s;
		logic signed [31:0] ly;
	} rot_in_t;

	// basis sequencer states
	typedef enum logic [4:0] {
		B_IDLE, B_A0, B_A1, B_A2, B_CHK, B_SQ, B_DLOAD, B_DRUN, B_SEL,
		B_N0, B_N1, B_NCHK, B_RSET, B_F0, B_F1, B_F2, B_F3, B_F4, B_F5
	} basis_state_t;

	localparam int SQRT_STEPS = 15;
	localparam int ATAN_ENTRIES = 24;

	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic [31:0] UP_Y_LIMIT_Q30 = 32'd1072668082;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic signed [32:0] ATAN_TURN [ATAN_ENTRIES] = '{
		33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
		33'sd42667331, 33'sd21354465, 33'sd10679838, 33'sd5340245,
		33'sd2670163, 33'sd1335087, 33'sd667544, 33'sd333772,
		33'sd166886, 33'sd83443, 33'sd41722, 33'sd20861,
		33'sd10430, 33'sd5215, 33'sd2608, 33'sd1304,
		33'sd652, 33'sd326, 33'sd163, 33'sd81
	};

	// clamp to 32 bit signed
	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -40'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage

/* rtl/core/ocps_basis.sv */
// ----------------------------------------------------------------------------
// ocps_basis
// Sequencer that derives the orthonormal basis from the axis registers with
// one shared multiplier, a bit-serial square root and a bit-serial divider.
// ----------------------------------------------------------------------------
module ocps_basis
	import ocps_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	output logic               busy,
	output basis_t             basis
);

	typedef enum logic [2:0] {
		D_UX = 3'd0,
		D_UY = 3'd1,
		D_UZ = 3'd2,
		D_NA = 3'd3,
		D_NB = 3'd4
	} div_sel_t;

	basis_state_t state_q, state_d;
	logic [5:0]   cnt_q;
	div_sel_t     didx_q;
	logic         ph_q;
	logic         sel_q;

	logic signed [63:0] acc_q;
	logic [63:0]        sq_rad_q;
	logic [33:0]        sq_rem_q;
	logic [31:0]        sq_root_q;
	logic [31:0]        len_q;
	logic [63:0]        dvd_q;
	logic [31:0]        drem_q;
	logic               neg_q;
	logic signed [31:0] a_q, b_q, na_q, nb_q;
	logic signed [31:0] rx_q, ry_q, rz_q, ux_q, uy_q, uz_q, fx_q, fy_q, fz_q;
	logic               deg_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod;
	logic signed [63:0] fwd_diff;
	logic [35:0]        sq_rem_n;
	logic [35:0]        sq_trial;
	logic               sq_ge;
	logic [31:0]        sq_root_n;
	logic [32:0]        dr_n;
	logic               dv_ge;
	logic [63:0]        quot_n;
	logic signed [31:0] div_res;
	logic [15:0]        ax_mag;
	logic               ax_neg;
	logic [32:0]        ab_mag;
	logic               ab_neg;
	logic [31:0]        uy_abs;
	logic               sq_last, dv_last;

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			B_A0:    begin mul_a = 32'(axis_x); mul_b = 32'(axis_x); end
			B_A1:    begin mul_a = 32'(axis_y); mul_b = 32'(axis_y); end
			B_A2:    begin mul_a = 32'(axis_z); mul_b = 32'(axis_z); end
			B_N0:    begin mul_a = a_q;  mul_b = a_q;  end
			B_N1:    begin mul_a = b_q;  mul_b = b_q;  end
			B_F0:    begin mul_a = uy_q; mul_b = rz_q; end
			B_F1:    begin mul_a = uz_q; mul_b = ry_q; end
			B_F2:    begin mul_a = uz_q; mul_b = rx_q; end
			B_F3:    begin mul_a = ux_q; mul_b = rz_q; end
			B_F4:    begin mul_a = ux_q; mul_b = ry_q; end
			B_F5:    begin mul_a = uy_q; mul_b = rx_q; end
			default: begin mul_a = '0;   mul_b = '0;   end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign fwd_diff = (acc_q - prod) >>> 30;

	// square root, one result bit per cycle
	assign sq_rem_n  = {sq_rem_q, sq_rad_q[63:62]};
	assign sq_trial  = 36'({sq_root_q, 2'b01});
	assign sq_ge     = sq_rem_n >= sq_trial;
	assign sq_root_n = {sq_root_q[30:0], sq_ge};
	assign sq_last   = cnt_q == 6'd31;

	// restoring divider, one quotient bit per cycle
	assign dr_n    = {drem_q, dvd_q[63]};
	assign dv_ge   = dr_n >= {1'b0, len_q};
	assign quot_n  = {dvd_q[62:0], dv_ge};
	assign div_res = neg_q ? 32'(-quot_n) : 32'(quot_n);
	assign dv_last = cnt_q == 6'd63;

	// numerator magnitude for the next division
	always_comb begin
		unique case (didx_q)
			D_UX:    ax_neg = axis_x[15];
			D_UY:    ax_neg = axis_y[15];
			default: ax_neg = axis_z[15];
		endcase
		unique case (didx_q)
			D_UX:    ax_mag = axis_x[15] ? 16'(-axis_x) : 16'(axis_x);
			D_UY:    ax_mag = axis_y[15] ? 16'(-axis_y) : 16'(axis_y);
			default: ax_mag = axis_z[15] ? 16'(-axis_z) : 16'(axis_z);
		endcase
		ab_neg = (didx_q == D_NA) ? a_q[31] : b_q[31];
		if (didx_q == D_NA)
			ab_mag = a_q[31] ? -33'(a_q) : 33'(a_q);
		else
			ab_mag = b_q[31] ? -33'(b_q) : 33'(b_q);
	end

	assign uy_abs = uy_q[31] ? 32'(-uy_q) : 32'(uy_q);

	// next state
	always_comb begin
		state_d = state_q;
		priority if (go) begin
			state_d = B_A0;
		end else begin
			unique case (state_q)
				B_IDLE:  state_d = B_IDLE;
				B_A0:    state_d = B_A1;
				B_A1:    state_d = B_A2;
				B_A2:    state_d = B_CHK;
				B_CHK:   state_d = (acc_q == '0) ? B_IDLE : B_SQ;
				B_SQ:    state_d = sq_last ? B_DLOAD : B_SQ;
				B_DLOAD: state_d = B_DRUN;
				B_DRUN: begin
					if (dv_last) begin
						if (didx_q == D_UZ)
							state_d = B_SEL;
						else if (didx_q == D_NB)
							state_d = B_RSET;
						else
							state_d = B_DLOAD;
					end
				end
				B_SEL:   state_d = B_N0;
				B_N0:    state_d = B_N1;
				B_N1:    state_d = B_NCHK;
				B_NCHK:  state_d = (acc_q == '0) ? B_RSET : B_SQ;
				B_RSET:  state_d = B_F0;
				B_F0:    state_d = B_F1;
				B_F1:    state_d = B_F2;
				B_F2:    state_d = B_F3;
				B_F3:    state_d = B_F4;
				B_F4:    state_d = B_F5;
				B_F5:    state_d = B_IDLE;
				default: state_d = B_IDLE;
			endcase
		end
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_A0;
			cnt_q   <= '0;
			didx_q  <= D_UX;
			ph_q    <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d == state_q) ? cnt_q + 6'd1 : '0;
			if (state_q == B_CHK)
				ph_q <= 1'b0;
			if (state_q == B_NCHK)
				ph_q <= 1'b1;
			if (state_q == B_SQ && sq_last)
				didx_q <= ph_q ? D_NA : D_UX;
			if (state_q == B_DRUN && dv_last && didx_q != D_UZ && didx_q != D_NB)
				didx_q <= div_sel_t'(didx_q + 3'd1);
			if (state_q == B_SEL)
				sel_q <= uy_abs >= UP_Y_LIMIT_Q30;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_A0, B_N0: acc_q <= prod;
			B_A1, B_A2, B_N1: acc_q <= acc_q + prod;
			B_CHK: begin
				deg_q     <= acc_q == '0;
				sq_rad_q  <= 64'(acc_q) << 30;
				sq_rem_q  <= '0;
				sq_root_q <= '0;
			end
			B_NCHK: begin
				sq_rad_q  <= 64'(acc_q);
				sq_rem_q  <= '0;
				sq_root_q <= '0;
				na_q      <= '0;
				nb_q      <= '0;
			end
			B_SQ: begin
				sq_rem_q  <= sq_ge ? 34'(sq_rem_n - sq_trial) : 34'(sq_rem_n);
				sq_root_q <= sq_root_n;
				sq_rad_q  <= sq_rad_q << 2;
				if (sq_last)
					len_q <= sq_root_n;
			end
			B_DLOAD: begin
				drem_q <= '0;
				if (didx_q == D_NA || didx_q == D_NB) begin
					dvd_q <= 64'(ab_mag) << 30;
					neg_q <= ab_neg;
				end else begin
					dvd_q <= 64'(ax_mag) << 45;
					neg_q <= ax_neg;
				end
			end
			B_DRUN: begin
				drem_q <= dv_ge ? 32'(dr_n - {1'b0, len_q}) : 32'(dr_n);
				dvd_q  <= quot_n;
				if (dv_last) begin
					unique case (didx_q)
						D_UX:    ux_q <= div_res;
						D_UY:    uy_q <= div_res;
						D_UZ:    uz_q <= div_res;
						D_NA:    na_q <= div_res;
						default: nb_q <= div_res;
					endcase
				end
			end
			B_SEL: begin
				if (uy_abs < UP_Y_LIMIT_Q30) begin
					a_q <= uz_q;
					b_q <= -ux_q;
				end else begin
					a_q <= -uz_q;
					b_q <= uy_q;
				end
			end
			B_RSET: begin
				rx_q <= sel_q ? 32'sd0 : na_q;
				ry_q <= sel_q ? na_q : 32'sd0;
				rz_q <= nb_q;
			end
			B_F0, B_F2, B_F4: acc_q <= prod;
			B_F1: fx_q <= 32'(fwd_diff);
			B_F3: fy_q <= 32'(fwd_diff);
			B_F5: fz_q <= 32'(fwd_diff);
			default: acc_q <= acc_q;
		endcase
	end

	assign busy = state_q != B_IDLE;

	assign basis = '{rx: rx_q, ry: ry_q, rz: rz_q, ux: ux_q, uy: uy_q, uz: uz_q,
		fx: fx_q, fy: fy_q, fz: fz_q, deg: deg_q};

endmodule

/* rtl/core/ocps_iter.sv */
// ----------------------------------------------------------------------------
// ocps_iter
// Pipelined CORDIC for cos/sin of the turn and pipelined square root of the
// radial sample, at most one iteration of each per stage.
// ----------------------------------------------------------------------------
module ocps_iter
	import ocps_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_v,
	input  iter_in_t in_d,
	output logic     out_v,
	output rot_in_t  out_d
);

	localparam int NSTG = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

	typedef struct packed {
		logic signed [33:0] cx;
		logic signed [33:0] cy;
		logic signed [32:0] cz;
		logic [1:0]         quad;
		logic [16:0]        srem;
		logic [14:0]        sroot;
		logic [29:0]        srad;
		logic signed [31:0] ly;
	} iter_t;

	iter_t iter_s [NSTG];
	logic  v_s    [NSTG];
	iter_t cur    [NSTG];
	iter_t nxt    [NSTG];
	iter_t last;

	// seed of the first stage
	assign cur[0] = '{cx: CORDIC_GAIN_Q30, cy: '0,
		cz: $signed({3'b000, in_d.rand_turn[13:0], 16'h0000}),
		quad: in_d.rand_turn[15:14], srem: '0, sroot: '0,
		srad: {in_d.rand_radial, 15'h0000}, ly: in_d.ly};

	for (genvar k = 0; k < NSTG; k++) begin : g_stage
		logic [18:0] rem_n;
		logic [18:0] trial;

		if (k > 0) begin : g_link
			assign cur[k] = iter_s[k-1];
		end

		assign rem_n = {cur[k].srem, cur[k].srad[29:28]};
		assign trial = 19'({cur[k].sroot, 2'b01});

		// one rotation and one root bit
		always_comb begin
			nxt[k] = cur[k];
			if (k < CORDIC_STEPS) begin
				if (!cur[k].cz[32]) begin
					nxt[k].cx = cur[k].cx - (cur[k].cy >>> k);
					nxt[k].cy = cur[k].cy + (cur[k].cx >>> k);
					nxt[k].cz = cur[k].cz - ATAN_TURN[k];
				end else begin
					nxt[k].cx = cur[k].cx + (cur[k].cy >>> k);
					nxt[k].cy = cur[k].cy - (cur[k].cx >>> k);
					nxt[k].cz = cur[k].cz + ATAN_TURN[k];
				end
			end
			if (k < SQRT_STEPS) begin
				if (rem_n >= trial) begin
					nxt[k].srem  = 17'(rem_n - trial);
					nxt[k].sroot = {cur[k].sroot[13:0], 1'b1};
				end else begin
					nxt[k].srem  = 17'(rem_n);
					nxt[k].sroot = {cur[k].sroot[13:0], 1'b0};
				end
				nxt[k].srad = cur[k].srad << 2;
			end
		end

		// stage register
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k] <= 1'b0;
			else if (en)
				v_s[k] <= (k == 0) ? in_v : v_s[(k == 0) ? 0 : k-1];
		end

		always_ff @(posedge clk) begin
			if (en)
				iter_s[k] <= nxt[k];
		end
	end

	assign last = iter_s[NSTG-1];

	// quadrant fold
	always_comb begin
		out_d.sq = last.sroot;
		out_d.ly = last.ly;
		unique case (last.quad)
			2'd0: begin out_d.c = 32'(last.cx);  out_d.s = 32'(last.cy);  end
			2'd1: begin out_d.c = 32'(-last.cy); out_d.s = 32'(last.cx);  end
			2'd2: begin out_d.c = 32'(-last.cx); out_d.s = 32'(-last.cy); end
			default: begin out_d.c = 32'(last.cy); out_d.s = 32'(-last.cx); end
		endcase
	end

	assign out_v = v_s[NSTG-1];

endmodule

/* rtl/core/ocps_rotate.sv */
// ----------------------------------------------------------------------------
// ocps_rotate
// Scales the unit circle point by the radius, rotates the local point into
// world space and adds the base position, five register stages.
// ----------------------------------------------------------------------------
module ocps_rotate
	import ocps_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  rot_in_t            in_d,
	input  logic [30:0]        cyl_radius,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] center_z,
	input  basis_t             basis,
	output logic               out_v,
	output out_item_t          out_d
);

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [30:0]        r_s1;
	logic signed [31:0] c_s1, s_s1, ly_s1;
	logic signed [31:0] l_s2 [3];
	logic signed [63:0] p_s3 [3][3];
	logic signed [65:0] sum_s4 [3];
	out_item_t          res_s5;

	logic [45:0]        rad_prod;
	logic signed [63:0] rc_prod, rs_prod;
	logic signed [31:0] row [3][3];
	logic signed [31:0] ctr [3];
	logic signed [31:0] pt [3];

	assign rad_prod = 46'(cyl_radius) * 46'(in_d.sq);
	assign rc_prod  = $signed({1'b0, r_s1}) * c_s1;
	assign rs_prod  = $signed({1'b0, r_s1}) * s_s1;

	// basis rows against local x, y, z
	assign row[0] = '{basis.rx, basis.ux, basis.fx};
	assign row[1] = '{basis.ry, basis.uy, basis.fy};
	assign row[2] = '{basis.rz, basis.uz, basis.fz};
	assign ctr    = '{center_x, center_y, center_z};

	for (genvar a = 0; a < 3; a++) begin : g_pt
		assign pt[a] = sat32(40'(sum_s4[a] >>> 30) + 40'(ctr[a]));
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			r_s1  <= 31'(rad_prod >> 15);
			c_s1  <= in_d.c;
			s_s1  <= in_d.s;
			ly_s1 <= in_d.ly;

			l_s2[0] <= sat32(40'(rc_prod >>> 30));
			l_s2[1] <= ly_s1;
			l_s2[2] <= sat32(40'(rs_prod >>> 30));

			for (int a = 0; a < 3; a++) begin
				for (int t = 0; t < 3; t++)
					p_s3[a][t] <= row[a][t] * l_s2[t];
				sum_s4[a] <= 66'(p_s3[a][0]) + 66'(p_s3[a][1]) + 66'(p_s3[a][2]);
			end

			if (basis.deg)
				res_s5 <= '{point_x: '0, point_y: '0, point_z: '0, axis_degenerate: 1'b1};
			else
				res_s5 <= '{point_x: pt[0], point_y: pt[1], point_z: pt[2],
					axis_degenerate: 1'b0};
		end
	end

	assign out_v = v_s5;
	assign out_d = res_s5;

endmodule

/* rtl/core/oriented_cylinder_point_sampler.sv */
// ----------------------------------------------------------------------------
// oriented_cylinder_point_sampler
// Maps three uniform samples to a world point inside a slab of an oriented
// cylinder; configuration registers, entry stages and pipeline control.
// ----------------------------------------------------------------------------
// The block takes one transaction per cycle while in_stall is low and returns
// one result per transaction, in order, after the entry stages, the CORDIC and
// square root stages and the rotation stages. The cylinder basis is recomputed
// by a sequencer after reset and after every write to an axis register: the
// input is stalled while the shared divider and square root unit work through
// it. Radius, height and center writes take effect at once. Results hold while
// out_stall is high.
module oriented_cylinder_point_sampler
	import ocps_pkg::*;
#(
	parameter int CORDIC_STEPS = 16,
	parameter int LENGTH_FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [30:0]        radius_q, height_q;
	logic signed [31:0] center_x_q, center_y_q, center_z_q;
	logic signed [15:0] axis_x_q, axis_y_q, axis_z_q;

	logic               en, in_acc, cfg_wr, axis_wr, busy;
	basis_t             basis;

	logic               v_s1, v_s2;
	logic signed [17:0] level_s1;
	logic [14:0]        radial_s1, radial_s2;
	logic [15:0]        turn_s1, turn_s2;
	logic signed [31:0] ly_s2;

	logic signed [16:0] slab_diff;
	logic signed [32:0] lvl_prod;
	logic signed [49:0] h_prod;

	iter_in_t           iter_in;
	logic               rot_v;
	rot_in_t            rot_in;

	// pipeline moves unless the held result is blocked
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en || busy;
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign axis_wr   = cfg_wr && (cfg_reg_t'(cfg_index) == REG_AXIS_X ||
		cfg_reg_t'(cfg_index) == REG_AXIS_Y || cfg_reg_t'(cfg_index) == REG_AXIS_Z);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q   <= 31'(64'd1 << LENGTH_FRAC_BITS);
			height_q   <= 31'(64'd1 << LENGTH_FRAC_BITS);
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			axis_x_q   <= '0;
			axis_y_q   <= 16'sd16384;
			axis_z_q   <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RADIUS:   radius_q   <= cfg_data[30:0];
				REG_HEIGHT:   height_q   <= cfg_data[30:0];
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				REG_CENTER_Z: center_z_q <= cfg_data;
				REG_AXIS_X:   axis_x_q   <= cfg_data[15:0];
				REG_AXIS_Y:   axis_y_q   <= cfg_data[15:0];
				REG_AXIS_Z:   axis_z_q   <= cfg_data[15:0];
				default:      radius_q   <= radius_q;
			endcase
		end
	end

	ocps_basis u_basis (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (axis_wr),
		.axis_x (axis_x_q),
		.axis_y (axis_y_q),
		.axis_z (axis_z_q),
		.busy   (busy),
		.basis  (basis)
	);

	// slab level and height along the axis
	assign slab_diff = $signed({1'b0, in_data.slab_end}) - $signed({1'b0, in_data.slab_start});
	assign lvl_prod  = $signed({1'b0, in_data.rand_level}) * slab_diff;
	assign h_prod    = level_s1 * $signed({1'b0, height_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			level_s1  <= $signed({2'b00, in_data.slab_start}) + 18'(lvl_prod >>> 15);
			radial_s1 <= in_data.rand_radial;
			turn_s1   <= in_data.rand_turn;
			ly_s2     <= sat32(40'(h_prod >>> 15));
			radial_s2 <= radial_s1;
			turn_s2   <= turn_s1;
		end
	end

	assign iter_in = '{rand_radial: radial_s2, rand_turn: turn_s2, ly: ly_s2};

	ocps_iter #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s2),
		.in_d   (iter_in),
		.out_v  (rot_v),
		.out_d  (rot_in)
	);

	ocps_rotate u_rotate (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_v       (rot_v),
		.in_d       (rot_in),
		.cyl_radius (radius_q),
		.center_x   (center_x_q),
		.center_y   (center_y_q),
		.center_z   (center_z_q),
		.basis      (basis),
		.out_v      (out_valid),
		.out_d      (out_data)
	);

endmodule

/* verif/ocps_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ocps_checker
// Watches the sample, result and configuration channels of the cylinder point
// sampler, predicts every result from its own copy of the registers and
// compares it field by field in order.
// ----------------------------------------------------------------------------
module ocps_checker
	import ocps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_item_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_item_t   out_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	localparam int TURN_STEPS = 16;

	// shadow copy of the registers
	longint radius_q, height_q, base_x, base_y, base_z, dir_x, dir_y, dir_z;

	out_item_t points_due[$];

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v)
			bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v = v - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// unit vector of a 2d pair in q2.30, zero when the pair is zero
	function automatic void unit_pair(input longint a, input longint b,
			output longint na, output longint nb);
		longint ln;
		ln = longint'(int_sqrt(longint'(a * a) + longint'(b * b)));
		if (ln == 0) begin
			na = 0;
			nb = 0;
		end else begin
			na = (a * 64'sd1073741824) / ln;
			nb = (b * 64'sd1073741824) / ln;
		end
	endfunction

	function automatic out_item_t predict_point(input in_item_t it);
		out_item_t res;
		longint nsq, ln, ux, uy, uz, rx, ry, rz, fx, fy, fz;
		longint sq, r, level, lx, ly, lz, c, s, x, y, z, dx, dy, ay;
		logic [1:0] quad;
		res = '0;
		nsq = dir_x * dir_x + dir_y * dir_y + dir_z * dir_z;
		if (nsq == 0) begin
			res.axis_degenerate = 1'b1;
			return res;
		end
		ln = longint'(int_sqrt(longint'(nsq) << 30));
		ux = (dir_x * 64'sd35184372088832) / ln;
		uy = (dir_y * 64'sd35184372088832) / ln;
		uz = (dir_z * 64'sd35184372088832) / ln;
		ay = (uy < 0) ? -uy : uy;
		// pick world y as helper unless the axis is nearly along it
		if (ay < longint'(UP_Y_LIMIT_Q30)) begin
			ry = 0;
			unit_pair(uz, -ux, rx, rz);
		end else begin
			rx = 0;
			unit_pair(-uz, uy, ry, rz);
		end
		fx = (uy * rz - uz * ry) >>> 30;
		fy = (uz * rx - ux * rz) >>> 30;
		fz = (ux * ry - uy * rx) >>> 30;

		sq = longint'(int_sqrt(longint'(it.rand_radial) << 15));
		r = (radius_q * sq) >> 15;
		level = longint'(it.slab_start) +
			((longint'(it.rand_level) *
			(longint'(it.slab_end) - longint'(it.slab_start))) >>> 15);
		ly = clamp32((level * height_q) >>> 15);

		// rotation mode cordic on the angle within one quadrant
		x = longint'(CORDIC_GAIN_Q30);
		y = 0;
		z = longint'(it.rand_turn[13:0]) << 16;
		for (int i = 0; i < TURN_STEPS && i < ATAN_ENTRIES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - longint'(ATAN_TURN[i]);
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + longint'(ATAN_TURN[i]);
			end
		end
		quad = it.rand_turn[15:14];
		case (quad)
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		lx = clamp32((r * c) >>> 30);
		lz = clamp32((r * s) >>> 30);

		res.point_x = 32'(clamp32(base_x + ((rx * lx + ux * ly + fx * lz) >>> 30)));
		res.point_y = 32'(clamp32(base_y + ((ry * lx + uy * ly + fy * lz) >>> 30)));
		res.point_z = 32'(clamp32(base_z + ((rz * lx + uz * ly + fz * lz) >>> 30)));
		return res;
	endfunction

	// register shadow, prediction and comparison
	always @(posedge clk or negedge arst_n) begin
		out_item_t due;
		if (!arst_n) begin
			radius_q = 65536;
			height_q = 65536;
			base_x = 0;
			base_y = 0;
			base_z = 0;
			dir_x = 0;
			dir_y = 16384;
			dir_z = 0;
			points_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// result transaction
			if (out_valid && !out_stall) begin
				if (points_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result x=%0d y=%0d z=%0d deg=%0b",
							out_data.point_x, out_data.point_y, out_data.point_z,
							out_data.axis_degenerate);
				end else begin
					due = points_due.pop_front();
					if (out_data.point_x !== due.point_x ||
							out_data.point_y !== due.point_y ||
							out_data.point_z !== due.point_z ||
							out_data.axis_degenerate !== due.axis_degenerate) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch exp x=%0d y=%0d z=%0d deg=%0b",
								due.point_x, due.point_y, due.point_z,
								due.axis_degenerate,
								" got x=%0d y=%0d z=%0d deg=%0b",
								out_data.point_x, out_data.point_y, out_data.point_z,
								out_data.axis_degenerate);
					end
				end
			end
			// sample transaction
			if (in_valid && !in_stall)
				points_due.insert(points_due.size(), predict_point(in_data));
			// register write
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_RADIUS:   radius_q = longint'(cfg_data[30:0]);
					REG_HEIGHT:   height_q = longint'(cfg_data[30:0]);
					REG_CENTER_X: base_x = longint'($signed(cfg_data));
					REG_CENTER_Y: base_y = longint'($signed(cfg_data));
					REG_CENTER_Z: base_z = longint'($signed(cfg_data));
					REG_AXIS_X:   dir_x = longint'($signed(cfg_data[15:0]));
					REG_AXIS_Y:   dir_y = longint'($signed(cfg_data[15:0]));
					REG_AXIS_Z:   dir_z = longint'($signed(cfg_data[15:0]));
					default: ;
				endcase
			end
			pending = points_due.size();
		end
	end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the cylinder point sampler: directed extremes, then random
// samples across many cylinder settings with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	import ocps_pkg::*;

	localparam int DRAIN_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	int          fail_count;
	int          pending;

	bit          send_busy;
	bit          recv_busy;
	int          recv_wait;

	oriented_cylinder_point_sampler uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ocps_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// run limit
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	// result side stall pattern, redrawn per result transaction
	initial begin
		out_stall = 1'b1;
		recv_wait = 0;
		forever begin
			@(negedge clk);
			if (recv_wait > 0) begin
				out_stall = 1'b1;
				recv_wait--;
			end else begin
				out_stall = 1'b0;
			end
			@(posedge clk);
			if (out_valid && !out_stall)
				recv_wait = recv_busy ? $urandom_range(0, 17) : 0;
		end
	end

	task automatic send_sample(input in_item_t it);
		int gap;
		gap = send_busy ? $urandom_range(0, 17) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		in_data = it;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	function automatic in_item_t make_sample(input int s0, input int s1, input int ur,
			input int tn, input int ul);
		in_item_t it;
		it.slab_start = 16'(s0);
		it.slab_end = 16'(s1);
		it.rand_radial = 15'(ur);
		it.rand_turn = 16'(tn);
		it.rand_level = 15'(ul);
		return it;
	endfunction

	function automatic in_item_t random_sample();
		int s0, s1;
		s0 = $urandom_range(0, 32768);
		s1 = $urandom_range(0, 32768);
		// mostly ordered slabs, some reversed
		if ($urandom_range(0, 3) != 0 && s1 < s0) begin
			s0 = s0 ^ s1;
			s1 = s0 ^ s1;
			s0 = s0 ^ s1;
		end
		if ($urandom_range(0, 15) == 0)
			s1 = 32768;
		return make_sample(s0, s1, $urandom, $urandom, $urandom);
	endfunction

	// wait for the pipeline to empty
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_cylinder(input logic [31:0] rad, input logic [31:0] hgt,
			input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz,
			input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az);
		drain();
		write_reg(REG_RADIUS, rad);
		write_reg(REG_HEIGHT, hgt);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CENTER_Z, cz);
		write_reg(REG_AXIS_X, {16'(0), ax});
		write_reg(REG_AXIS_Y, {16'(0), ay});
		write_reg(REG_AXIS_Z, {16'(0), az});
	endtask

	task automatic directed_run();
		send_sample(make_sample(0, 0, 0, 0, 0));
		send_sample(make_sample(0, 32768, 32767, 65535, 32767));
		send_sample(make_sample(32768, 0, 32767, 16384, 16384));
		send_sample(make_sample(32768, 32768, 0, 32768, 0));
		send_sample(make_sample(0, 32768, 16384, 49152, 32767));
		send_sample(make_sample(21845, 10922, 1, 16383, 1));
		send_sample(make_sample(1, 32767, 32767, 1, 21845));
	endtask

	initial begin
		int rad, ax, ay, az;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_busy = 1'b1;
		recv_busy = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings, then degenerate axis
		directed_run();
		set_cylinder(32'd65536, 32'd65536, 0, 0, 0, 16'd0, 16'd0, 16'd0);
		directed_run();
		// largest sizes and far corner
		set_cylinder(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 16'h8000, 16'h8000, 16'h8000);
		directed_run();
		// zero sizes, near corner, axis down world y
		set_cylinder(0, 0, 32'h80000000, 32'h80000000, 32'h80000000,
			16'd0, -16'sd16384, 16'd0);
		directed_run();
		set_cylinder(32'd300000, 32'd500000, 32'hfff00000, 32'h00100000, 0,
			16'h7fff, 16'd0, 16'd1);
		directed_run();

		// random settings and samples
		for (int ph = 0; ph < 12; ph++) begin
			send_busy = (ph % 4) != 1;
			recv_busy = (ph % 4) != 2;
			rad = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1 << 22);
			ax = $urandom;
			ay = $urandom;
			az = $urandom;
			// some axes nearly along world y
			if ($urandom_range(0, 3) == 0) begin
				ax = $urandom_range(0, 15);
				az = $urandom_range(0, 15);
				ay = $urandom_range(0, 1) ? 16000 : -16000;
			end
			set_cylinder(rad, $urandom_range(0, 1 << 22), $urandom, $urandom, $urandom,
				16'(ax), 16'(ay), 16'(az));
			for (int n = 0; n < 120; n++)
				send_sample(random_sample());
		end

		drain();
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
